>>> rtl/core/smm_pkg.sv
package smm_pkg;

  localparam int MAX_ORDER = 8;
  localparam int IDX_W     = $clog2(MAX_ORDER);
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int DEPTH     = MAX_ORDER * MAX_ORDER;
  localparam int DIM_W     = 4;
  localparam int VAL_W     = 32;
  localparam int PROD_W    = 64;
  localparam int FRAC_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = DIM_W;

  localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum logic [1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_START  = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MATRIX_SIZE = 2'd0,
    CFG_B_COLUMNS   = 2'd1,
    CFG_UNUSED_2    = 2'd2,
    CFG_UNUSED_3    = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic vld;
    logic first;
    logic final_term;
  } mac_ctl_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) r = DIM_W'(1);
    else if (v > DIM_W'(MAX_ORDER)) r = DIM_W'(MAX_ORDER);
    else r = v;
    return r;
  endfunction

endpackage

>>> rtl/core/smm_ifs.sv
interface smm_in_if;
  import smm_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [1:0]              opcode;
  logic [2:0]              row_index;
  logic [2:0]              col_index;
  logic signed [VAL_W-1:0] element_value;

  modport source (output valid, opcode, row_index, col_index, element_value, input ready);
  modport sink (input valid, opcode, row_index, col_index, element_value, output ready);
endinterface

interface smm_out_if;
  import smm_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [2:0]              out_row;
  logic [2:0]              out_col;
  logic signed [VAL_W-1:0] product_value;
  logic                    saturated;
  logic                    last;

  modport source (output valid, out_row, out_col, product_value, saturated, last,
                  input ready);
  modport sink (input valid, out_row, out_col, product_value, saturated, last,
                output ready);
endinterface

>>> rtl/core/square_matrix_multiply_core.sv
// Q16.16 matrix multiplier: P = A * B, A is n by n, B is n by c.
// cmd channel: one word per operation. Load A / load B write one element
// into the A or B store in the accept cycle; start runs the whole product.
// result channel: one word per product element, row-major, last flags the
// final element. Config port sets n (matrix_size) and c (b_columns);
// write it only while idle. Values 0 and above 8 act as 1 and 8.
// For each product element of a start, one MAC unit issues one A/B store
// read pair per cycle, then the memory read, multiply and accumulate stages
// drain before the element is moved to the output register. cmd is not ready
// during a run; the next element is computed while the previous one waits
// in the output register.
// A stall on result holds the output register and, one element later, the
// sequencer; nothing is dropped. Reset clears control and config (n = c = 8)
// but not the stores: every element read by a start must be loaded first.
module square_matrix_multiply_core
  import smm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  smm_in_if.sink               cmd,
  smm_out_if.source            result
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RUN  = 4'b0010,
    ST_WAIT = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [DIM_W-1:0] matrix_size, b_columns;
  logic [DIM_W-1:0] n_dim, c_dim;
  logic [IDX_W-1:0] i_idx, j_idx, k_idx;
  logic             k_end, i_end, j_end;
  logic             cmd_fire, load_ok, emit_load;
  mac_ctl_t         rd_ctl;
  logic [VAL_W-1:0] a_rdata, b_rdata;
  logic             mac_done;
  logic [VAL_W-1:0] sum_value;
  logic             sum_sat;
  opcode_t          op;

  assign n_dim = clamp_dim(matrix_size);
  assign c_dim = clamp_dim(b_columns);
  assign k_end = k_idx == IDX_W'(n_dim - DIM_W'(1));
  assign i_end = i_idx == IDX_W'(n_dim - DIM_W'(1));
  assign j_end = j_idx == IDX_W'(c_dim - DIM_W'(1));

  assign op        = opcode_t'(cmd.opcode);
  assign cmd.ready = state == ST_IDLE;
  assign cmd_fire  = cmd.valid && cmd.ready;
  assign load_ok   = {1'b0, cmd.row_index} < (IDX_W+1)'(MAX_ORDER) &&
                     {1'b0, cmd.col_index} < (IDX_W+1)'(MAX_ORDER);
  assign emit_load = state == ST_EMIT && (!result.valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size <= DIM_W'(MAX_ORDER);
      b_columns   <= DIM_W'(MAX_ORDER);
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_MATRIX_SIZE: matrix_size <= cfg_data;
        CFG_B_COLUMNS:   b_columns   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (cmd_fire && op == OP_START) state_next = ST_RUN;
      ST_RUN:  if (k_end) state_next = ST_WAIT;
      ST_WAIT: if (mac_done) state_next = ST_EMIT;
      ST_EMIT: if (emit_load) state_next = (i_end && j_end) ? ST_IDLE : ST_RUN;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      i_idx        <= '0;
      j_idx        <= '0;
      k_idx        <= '0;
      rd_ctl       <= '0;
      result.valid <= 1'b0;
    end else begin
      state      <= state_next;
      rd_ctl.vld <= state == ST_RUN;
      rd_ctl.first      <= k_idx == '0;
      rd_ctl.final_term <= k_end;
      if (state == ST_RUN) begin
        k_idx <= k_end ? '0 : k_idx + IDX_W'(1);
      end
      if (emit_load) begin
        if (j_end) begin
          j_idx <= '0;
          i_idx <= i_end ? '0 : i_idx + IDX_W'(1);
        end else begin
          j_idx <= j_idx + IDX_W'(1);
        end
      end
      if (emit_load) result.valid <= 1'b1;
      else if (result.ready) result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      result.out_row       <= i_idx;
      result.out_col       <= j_idx;
      result.product_value <= sum_value;
      result.saturated     <= sum_sat;
      result.last          <= i_end && j_end;
    end
  end

  smm_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_a_store (
    .clk   (clk),
    .we    (cmd_fire && op == OP_LOAD_A && load_ok),
    .waddr ({cmd.row_index, cmd.col_index}),
    .wdata (cmd.element_value),
    .re    (state == ST_RUN),
    .raddr ({i_idx, k_idx}),
    .rdata (a_rdata)
  );

  smm_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_b_store (
    .clk   (clk),
    .we    (cmd_fire && op == OP_LOAD_B && load_ok),
    .waddr ({cmd.row_index, cmd.col_index}),
    .wdata (cmd.element_value),
    .re    (state == ST_RUN),
    .raddr ({k_idx, j_idx}),
    .rdata (b_rdata)
  );

  smm_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .ctl       (rd_ctl),
    .a_data    (a_rdata),
    .b_data    (b_rdata),
    .done      (mac_done),
    .sum_value (sum_value),
    .sum_sat   (sum_sat)
  );

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    mac_done |-> state == ST_WAIT)
    else $error("accumulator finished outside wait state");

  a_rd_busy: assert property (@(posedge clk) disable iff (rst)
    rd_ctl.vld |-> (state == ST_RUN || state == ST_WAIT))
    else $error("store read in flight while idle or emitting");

  a_k_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN |-> {1'b0, k_idx} < n_dim)
    else $error("inner index past matrix order");

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    emit_load |=> result.valid)
    else $error("emitted element not presented");

endmodule

>>> rtl/core/smm_ram.sv
module smm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/smm_mac.sv
module smm_mac
  import smm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  mac_ctl_t                ctl,
  input  logic signed [VAL_W-1:0] a_data,
  input  logic signed [VAL_W-1:0] b_data,
  output logic                    done,
  output logic [VAL_W-1:0]        sum_value,
  output logic                    sum_sat
);

  mac_ctl_t                 prod_ctl;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] acc;
  logic [PROD_W-FRAC_W-1:0] sh;
  logic [PROD_W-FRAC_W-VAL_W:0] sh_hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_ctl <= '0;
      done     <= 1'b0;
    end else begin
      prod_ctl <= ctl;
      done     <= prod_ctl.vld && prod_ctl.final_term;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.vld) begin
      prod <= PROD_W'(a_data) * PROD_W'(b_data);
    end
    if (prod_ctl.vld) begin
      acc <= prod_ctl.first ? prod : acc + prod;
    end
  end

  // floor shift, then clip to 32 bits
  always_comb begin
    sh    = acc[PROD_W-1:FRAC_W];
    sh_hi = sh[PROD_W-FRAC_W-1:VAL_W-1];
    if (sh_hi == '0 || sh_hi == '1) begin
      sum_value = sh[VAL_W-1:0];
      sum_sat   = 1'b0;
    end else begin
      sum_value = acc[PROD_W-1] ? VAL_MIN : VAL_MAX;
      sum_sat   = 1'b1;
    end
  end

endmodule
